>>> hw/rtl/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg: shared types and constants of the linear probe key table
// Codes for slot marks, request modes and result status, the hash
// multiplier, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpkt_pkg;

    // Defaults for the top level parameters (slot count is a power of two)
    localparam int DEF_TABLE_SLOTS = 4096;
    localparam int DEF_KEY_BITS    = 22;

    // Multiplicative hash constant (mod 2^32)
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // Request modes; the unused code behaves as a lookup
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_CREATE = 2'd1;
    localparam logic [1:0] MODE_FORGET = 2'd2;

    // Result status
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;    // write one empty slot of the clearing pass
        logic load;      // take a request, hash its key
        logic rd_en;     // read the slot memory
        logic rd_next;   // read the slot after the current probe
        logic advance;   // move the probe to the next slot
        logic finish;    // close the probe, update table and count
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // probed slot is used and holds the key
        logic empty;     // probed slot is empty
        logic last;      // probed slot is the last one not yet visited
        logic clr_last;  // clearing pass writes its final slot
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/lpkt_ram.sv
// ----------------------------------------------------------------------------
// lpkt_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = lpkt_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lpkt_dpath.sv
// ----------------------------------------------------------------------------
// lpkt_dpath: datapath of the linear probe key table
// Hash unit, probe pointer and counter, slot memory, live count, result
// and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkt_dpath #(
    parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = lpkt_pkg::DEF_KEY_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lpkt_pkg::t_cmd                 i_cmd,
    output lpkt_pkg::t_sts                      o_sts,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [KEY_BITS-1:0]            i_key,
    output logic      [1:0]                     o_status,
    output logic      [$clog2(TABLE_SLOTS)-1:0] o_slot_index,
    output logic      [$clog2(TABLE_SLOTS):0]   o_live_count
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int WORD_BITS = KEY_BITS + 2;
    localparam logic [SLOT_BITS-1:0] MultLo = SLOT_BITS'(lpkt_pkg::HASH_MULT);

    logic [1:0]           r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [SLOT_BITS-1:0] r_idx,  n_idx;
    logic [SLOT_BITS-1:0] r_cnt,  n_cnt;
    logic [SLOT_BITS-1:0] r_clr;
    logic [SLOT_BITS:0]   r_live, n_live;
    logic [1:0]           r_res_status, n_res_status;
    logic [SLOT_BITS-1:0] r_res_slot,   n_res_slot;

    logic [SLOT_BITS-1:0] prod;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] wr_word;
    logic [SLOT_BITS-1:0] wr_addr;
    logic [SLOT_BITS-1:0] rd_addr;
    logic [1:0]           rd_mark;
    logic [1:0]           wr_mark;
    logic [KEY_BITS-1:0]  rd_key;
    logic                 wr_en;
    logic                 do_tomb;
    logic                 do_claim;

    // Home slot: low bits of key * multiplier depend only on low operand bits
    assign prod = SLOT_BITS'(i_key) * MultLo;

    assign rd_mark = rd_word[1:0];
    assign rd_key  = rd_word[WORD_BITS-1:2];

    assign o_sts.hit      = (rd_mark == lpkt_pkg::MARK_USED) && (rd_key == r_key);
    assign o_sts.empty    = (rd_mark == lpkt_pkg::MARK_EMPTY);
    assign o_sts.last     = &r_cnt;
    assign o_sts.clr_last = &r_clr;

    assign do_tomb  = i_cmd.finish && o_sts.hit && (r_mode == lpkt_pkg::MODE_FORGET);
    assign do_claim = i_cmd.finish && !o_sts.hit && o_sts.empty
                      && (r_mode == lpkt_pkg::MODE_CREATE);

    always_comb begin
        wr_en   = i_cmd.clr_wr || do_tomb || do_claim;
        wr_addr = i_cmd.clr_wr ? r_clr : r_idx;
        if (i_cmd.clr_wr) begin
            wr_mark = lpkt_pkg::MARK_EMPTY;
        end else if (do_tomb) begin
            wr_mark = lpkt_pkg::MARK_TOMB;
        end else begin
            wr_mark = lpkt_pkg::MARK_USED;
        end
        wr_word = {r_key, wr_mark};
        // Prefetch the following slot while the current one is checked
        rd_addr = i_cmd.rd_next ? r_idx + 1'b1 : r_idx;
    end

    always_comb begin
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_live       = r_live;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        if (i_cmd.load) begin
            n_idx = prod;
            n_cnt = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end
        if (do_tomb) begin
            n_live = r_live - 1'b1;
        end else if (do_claim) begin
            n_live = r_live + 1'b1;
        end
        if (i_cmd.finish) begin
            if (o_sts.hit) begin
                n_res_status = lpkt_pkg::ST_FOUND;
                n_res_slot   = r_idx;
            end else if (do_claim) begin
                n_res_status = lpkt_pkg::ST_CREATED;
                n_res_slot   = r_idx;
            end else if (o_sts.empty) begin
                n_res_status = lpkt_pkg::ST_ABSENT;
                n_res_slot   = '0;
            end else begin
                n_res_status = lpkt_pkg::ST_FULL;
                n_res_slot   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_live <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            r_live <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (i_cmd.out_load) begin
            o_status     <= r_res_status;
            o_slot_index <= r_res_slot;
            o_live_count <= r_live;
        end
    end

    lpkt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lpkt_ctrl.sv
// ----------------------------------------------------------------------------
// lpkt_ctrl: controller of the linear probe key table
// Sequences the clearing pass, request intake, probe walk and result
// hand-off; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire lpkt_pkg::t_sts i_sts,
    output lpkt_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   stop;
    logic   out_free;

    assign stop        = i_sts.hit || i_sts.empty || i_sts.last;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                if (stop) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    o_cmd.advance = 1'b1;
                end
            end
            S_DONE: begin
                // hold until the previous beat is taken
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// linear_probe_key_table: hash table of process keys, linear probing
//
//   channel  valid         ready         payload
//   request  i_in_valid    o_in_ready    i_mode, i_key
//   result   o_out_valid   i_out_ready   o_status, o_slot_index, o_live_count
//
// A request goes through intake, a first read, the probe walk and the result
// hand-off; the walk starts at the home slot, stops at a hit, an empty slot
// or the TABLE_SLOTS-th probe, and reads one slot per cycle from the single
// read port of the slot memory. After reset a clearing pass marks every
// slot empty, with no request accepted.
// A new request is taken while the previous result waits; a finished result
// holds in the controller until the output register is free.
// TABLE_SLOTS is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_key_table #(
    parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = lpkt_pkg::DEF_KEY_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [KEY_BITS-1:0]            i_key,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [1:0]                     o_status,
    output logic      [$clog2(TABLE_SLOTS)-1:0] o_slot_index,
    output logic      [$clog2(TABLE_SLOTS):0]   o_live_count
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);

    lpkt_pkg::t_cmd cmd;
    lpkt_pkg::t_sts sts;

    lpkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lpkt_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_live_count (o_live_count)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_live_count <= (SLOT_BITS + 1)'(TABLE_SLOTS)))
        else $error("live count above table size");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lpkt_pkg::ST_ABSENT
                         || o_status == lpkt_pkg::ST_FULL))
        |-> (o_slot_index == '0))
        else $error("slot index set on a miss");

    a_fresh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready || !$past(o_in_ready))
        else $error("result raised without a request in flight");

endmodule

`default_nettype wire
